// ===== hw/rtl/modexp_pkg.sv =====
package modexp_pkg;

	localparam int unsigned WIDTH_DEF = 32;
	localparam logic [31:0] EXP_RST = 32'd65537;
	localparam logic [31:0] MOD_RST = 32'd4294967291;

	localparam logic REG_EXPONENT = 1'b0;
	localparam logic REG_MODULUS  = 1'b1;

	// Controller states
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RED  = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_SQR  = 6'b001000,
		ST_NEXT = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	// Control from sequencer to the cell row
	typedef struct packed {
		logic start;
		logic step;
		logic bit_in;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/modexp_cell.sv =====
// One cell of the serial modular multiplier row: doubles the partial
// product, adds the operand when the incoming multiplier bit is set, and
// reduces both times.
module modexp_cell import modexp_pkg::*; #(
	parameter int unsigned WIDTH = WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             step,
	input  logic             bit_in,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] m,
	output logic [WIDTH-1:0] r
);
	logic [WIDTH-1:0] r_q;
	logic [WIDTH:0]   dbl;
	logic [WIDTH-1:0] dbl_red;
	logic [WIDTH:0]   sum;
	logic [WIDTH-1:0] nxt;

	// r = 2r mod m, then + a mod m when bit_in is set
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= {1'b0, m}) ? WIDTH'(dbl - {1'b0, m}) : dbl[WIDTH-1:0];
		sum     = {1'b0, dbl_red} + {1'b0, a};
		if (bit_in) begin
			nxt = (sum >= {1'b0, m}) ? WIDTH'(sum - {1'b0, m}) : sum[WIDTH-1:0];
		end else begin
			nxt = dbl_red;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
		end else if (start) begin
			r_q <= '0;
		end else if (step) begin
			r_q <= nxt;
		end
	end

	assign r = r_q;
endmodule

// ===== hw/rtl/modexp_row.sv =====
// Row of two cells driven by the bits of base: cell 0 forms acc*base
// (its bits gated by the exponent bit), cell 1 forms base*base, both over WIDTH steps.
module modexp_row import modexp_pkg::*; #(
	parameter int unsigned WIDTH = WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic             bit_sq,
	input  logic [WIDTH-1:0] acc,
	input  logic [WIDTH-1:0] base,
	input  logic [WIDTH-1:0] m,
	output logic [WIDTH-1:0] prod_mul,
	output logic [WIDTH-1:0] prod_sqr
);
	modexp_cell #(.WIDTH(WIDTH)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(ctl.start), .step(ctl.step),
		.bit_in(ctl.bit_in), .a(acc), .m(m), .r(prod_mul)
	);

	modexp_cell #(.WIDTH(WIDTH)) u_sqr (
		.clk(clk), .arst_n(arst_n), .start(ctl.start), .step(ctl.step),
		.bit_in(bit_sq), .a(base), .m(m), .r(prod_sqr)
	);
endmodule

// ===== hw/rtl/modular_exponentiation.sv =====
// Channel | Direction | Handshake         | Payload
// in      | input     | in_valid/in_stall | message
// out     | output    | out_valid/out_stall | result
// cfg     | input     | cfg_we            | cfg_index, cfg_data
//
// One transaction at a time. The message is first reduced by modulus; then
// each exponent bit is processed in the two-cell multiplier row (multiply and
// square run side by side). The next message can be taken in the same cycle
// that the result becomes valid. A result still stalled on the output holds
// the finished item back. Reset restores the configuration registers.
module modular_exponentiation import modexp_pkg::*; #(
	parameter int unsigned WIDTH = WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int unsigned CW = $clog2(WIDTH + 1);
	localparam int unsigned IW = $clog2(WIDTH);

	logic [WIDTH-1:0] exp_q, mod_q, acc_q, base_q, e_q, msg_q;
	logic [CW-1:0]    cnt_q, ebit_q;
	logic [IW-1:0]    bidx;
	logic [31:0]      res_q;
	logic             res_v_q, pend_q;
	state_t           st_q;
	cell_ctl_t        ctl;
	logic [WIDTH-1:0] prod_mul, prod_sqr, rdiv_n;
	logic [WIDTH:0]   rdiv_w;
	logic             in_acc, out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall  = pend_q;
	assign out_valid = res_v_q;
	assign result    = res_q;

	// bit position handled this cycle, MSB first
	assign bidx = IW'(cnt_q - CW'(1));

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= WIDTH'(EXP_RST);
			mod_q <= WIDTH'(MOD_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXPONENT: exp_q <= WIDTH'(cfg_data);
				REG_MODULUS:  mod_q <= WIDTH'(cfg_data);
				default: ;
			endcase
		end
	end

	// Restoring reduction of message by modulus, one bit per cycle
	always_comb begin
		rdiv_w = {acc_q, msg_q[bidx]};
		rdiv_n = (rdiv_w >= {1'b0, mod_q}) ? WIDTH'(rdiv_w - {1'b0, mod_q})
			: rdiv_w[WIDTH-1:0];
	end

	// Cell row control: multiplier bits from MSB of base
	always_comb begin
		ctl.start  = (st_q == ST_NEXT) || (st_q == ST_RED && cnt_q == '0);
		ctl.step   = (st_q == ST_MUL);
		ctl.bit_in = base_q[bidx] & e_q[0];
	end

	modexp_row #(.WIDTH(WIDTH)) u_row (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.bit_sq(base_q[bidx]),
		.acc(acc_q), .base(base_q), .m(mod_q),
		.prod_mul(prod_mul), .prod_sqr(prod_sqr)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			pend_q  <= 1'b0;
			res_v_q <= 1'b0;
			cnt_q   <= '0;
			ebit_q  <= '0;
		end else begin
			if (out_acc && st_q != ST_OUT) res_v_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						pend_q <= 1'b1;
						cnt_q  <= CW'(WIDTH);
						st_q   <= ST_RED;
					end
				end
				ST_RED: begin
					if (cnt_q == CW'(1)) begin
						cnt_q  <= CW'(WIDTH);
						ebit_q <= '0;
						st_q   <= ST_NEXT;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_NEXT: begin
					cnt_q <= CW'(WIDTH);
					st_q  <= (ebit_q == CW'(WIDTH)) ? ST_OUT : ST_MUL;
				end
				ST_MUL: begin
					if (cnt_q == CW'(1)) st_q <= ST_SQR;
					cnt_q <= cnt_q - CW'(1);
				end
				ST_SQR: begin
					ebit_q <= ebit_q + CW'(1);
					st_q   <= ST_NEXT;
				end
				ST_OUT: begin
					if (!res_v_q || out_acc) begin
						res_v_q <= 1'b1;
						pend_q  <= 1'b0;
						st_q    <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				msg_q <= WIDTH'(message);
				acc_q <= '0;
				e_q   <= exp_q;
			end
			ST_RED: begin
				if (cnt_q == CW'(1)) begin
					base_q <= (mod_q == '0) ? '0 : rdiv_n;
					acc_q  <= (mod_q == WIDTH'(1) || mod_q == '0) ? '0 : WIDTH'(1);
				end else if (mod_q == '0) begin
					acc_q <= '0;
				end else begin
					acc_q <= rdiv_n;
				end
			end
			ST_SQR: begin
				if (e_q[0]) acc_q <= prod_mul;
				base_q <= prod_sqr;
				e_q    <= e_q >> 1;
			end
			ST_OUT: begin
				if (!res_v_q || out_acc) res_q <= 32'(acc_q);
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> in_stall) else $error("accept while busy");
	a_res_lt_mod: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_v_q) && mod_q != '0 |-> res_q < 32'(mod_q)) else $error("unreduced");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q)) else $error("state not one-hot");
	a_idle_free: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_IDLE |-> !pend_q) else $error("idle but pending");
`endif
endmodule

// ===== verif/tb_modular_exponentiation.sv =====
module tb_modular_exponentiation;
	import modexp_pkg::*;

	localparam int unsigned MAX_CYCLES = 6_000_000;
	localparam int unsigned N_RANDOM = 270;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] message;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] result;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;

	// shadow copy of the configuration registers
	logic [31:0] pow_reg;
	logic [31:0] mod_reg;

	logic [31:0] expected_results[$];
	int          mismatches;
	int          cycle_count;
	bit          hold_off;
	bit          done;

	// directed row: message, with a typed-in answer where obvious
	typedef struct {
		logic [31:0] msg;
		bit          known;
		logic [31:0] want;
	} directed_row_t;

	modular_exponentiation dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .message(message),
		.out_valid(out_valid), .out_stall(out_stall), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// (a * b) mod m, both operands already reduced
	function automatic logic [31:0] mulmod(logic [31:0] a, logic [31:0] b, logic [31:0] m);
		logic [63:0] prod;
		prod = 64'(a) * 64'(b);
		return 32'(prod % 64'(m));
	endfunction

	// right-to-left square-and-multiply
	function automatic logic [31:0] modpow(logic [31:0] msg, logic [31:0] e,
		logic [31:0] m);
		logic [31:0] base;
		logic [31:0] acc;
		if (m == 0)
			return 32'd0;
		base = msg % m;
		acc = 32'd1 % m;
		for (int i = 0; i < 32; i++) begin
			if (e[i])
				acc = mulmod(acc, base, m);
			base = mulmod(base, base, m);
		end
		return acc;
	endfunction

	task automatic write_reg(logic idx, logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_EXPONENT)
			pow_reg = value;
		else
			mod_reg = value;
	endtask

	// wait for the pipe to drain, then a margin before touching registers
	task automatic drain();
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return;
		else if (r < 90)
			repeat ($urandom_range(1, 5)) @(negedge clk);
		else
			repeat ($urandom_range(20, 3000)) @(negedge clk);
	endtask

	// offer one transaction and wait for acceptance
	task automatic send_message(logic [31:0] msg, bit known, logic [31:0] want);
		in_valid = 1'b1;
		message = msg;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_results.push_back(known ? want : modpow(msg, pow_reg, mod_reg));
		@(negedge clk);
		in_valid = 1'b0;
		message = $urandom();
	endtask

	function automatic logic [31:0] rand_message();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return mod_reg;
			3: return mod_reg - 1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] rand_modulus();
		case ($urandom_range(0, 6))
			0: return 32'd1;
			1: return 32'd2;
			2: return 32'hFFFF_FFFF;
			3: return 32'h8000_0000 | $urandom();
			4: return 32'd1 + $urandom_range(0, 1000);
			default: return ($urandom() | 32'd1);
		endcase
	endfunction

	function automatic logic [31:0] rand_exponent();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// result checking against the oldest expectation
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: result=%h", result);
			end else begin
				want = expected_results.pop_front();
				if (result !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %h, got %h", want, result);
				end
			end
		end
	end

	// receiver stall pattern, with one forced long hold-off
	always @(negedge clk) begin
		if (hold_off)
			out_stall <= 1'b1;
		else if ($urandom_range(0, 9) < 3)
			out_stall <= 1'b1;
		else
			out_stall <= 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLES && !done) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		directed_row_t rows[$];
		int hold_cycles;

		arst_n = 1'b0;
		in_valid = 1'b0;
		message = '0;
		cfg_we = 1'b0;
		cfg_index = REG_EXPONENT;
		cfg_data = '0;
		hold_off = 1'b0;
		done = 1'b0;
		mismatches = 0;
		cycle_count = 0;
		pow_reg = EXP_RST;
		mod_reg = MOD_RST;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: 0 -> 0, 1 -> 1, modulus -> 0, others via predictor
		rows = '{
			'{32'd0, 1'b1, 32'd0},
			'{32'd1, 1'b1, 32'd1},
			'{32'hFFFF_FFFF, 1'b0, 32'd0},
			'{MOD_RST, 1'b1, 32'd0},
			'{32'd2, 1'b0, 32'd0},
			'{32'h8000_0000, 1'b0, 32'd0}
		};
		foreach (rows[i])
			send_message(rows[i].msg, rows[i].known, rows[i].want);
		drain();

		// zero exponent: one, also for a zero message
		write_reg(REG_EXPONENT, 32'd0);
		rows = '{
			'{32'd0, 1'b1, 32'd1},
			'{32'hFFFF_FFFF, 1'b1, 32'd1},
			'{32'h1234_5678, 1'b1, 32'd1}
		};
		foreach (rows[i])
			send_message(rows[i].msg, rows[i].known, rows[i].want);
		drain();

		// modulus of one: everything collapses to zero
		write_reg(REG_MODULUS, 32'd1);
		send_message(32'd0, 1'b1, 32'd0);
		drain();
		write_reg(REG_EXPONENT, 32'hFFFF_FFFF);
		rows = '{
			'{32'd0, 1'b1, 32'd0},
			'{32'hFFFF_FFFF, 1'b1, 32'd0},
			'{32'd7, 1'b1, 32'd0}
		};
		foreach (rows[i])
			send_message(rows[i].msg, rows[i].known, rows[i].want);
		drain();

		// largest modulus with largest exponent and exponent one, then modulus two
		write_reg(REG_MODULUS, 32'hFFFF_FFFF);
		send_message(32'hFFFF_FFFE, 1'b0, 32'd0);
		send_message(32'hFFFF_FFFF, 1'b1, 32'd0);
		send_message(32'd3, 1'b0, 32'd0);
		drain();
		write_reg(REG_EXPONENT, 32'd1);
		send_message(32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE);
		send_message(32'h5555_5555, 1'b1, 32'h5555_5555);
		drain();
		write_reg(REG_MODULUS, 32'd2);
		send_message(32'hAAAA_AAAB, 1'b1, 32'd1);
		send_message(32'hAAAA_AAAA, 1'b1, 32'd0);
		drain();

		// long receiver hold-off while the sender keeps offering
		hold_off = 1'b1;
		fork
			begin
				hold_cycles = 6000;
				repeat (hold_cycles) @(negedge clk);
				hold_off = 1'b0;
			end
			for (int k = 0; k < 4; k++)
				send_message($urandom(), 1'b0, 32'd0);
		join
		drain();

		// random phases with fresh settings between them
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 30 == 0) begin
				drain();
				write_reg(REG_MODULUS, rand_modulus());
				write_reg(REG_EXPONENT, rand_exponent());
			end
			random_gap();
			send_message(rand_message(), 1'b0, 32'd0);
		end

		drain();
		repeat (100) @(negedge clk);
		done = 1'b1;
		if (mismatches == 0 && expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/modexp_pkg.sv
hw/rtl/modexp_cell.sv
hw/rtl/modexp_row.sv
hw/rtl/modular_exponentiation.sv
verif/tb_modular_exponentiation.sv
